/* hw/rtl/mpsc_pkg.sv */
// Shared types, constants and helpers for the motor speed/position controller.
// No dependencies; every other file of the block imports this package.
package mpsc_pkg;

    localparam int FRAC_BITS = 24;
    localparam int POS_BITS  = 24;
    localparam int EDGE_BITS = 10;
    localparam int TS_W      = 14;
    localparam int FIN_W     = 24;
    localparam int FILT_W    = 48;
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = 25;
    localparam int DRIVE_W   = 9;
    localparam int ACC_W     = 64;
    localparam int OPND_W    = 49;
    localparam int MAG_W     = 48;
    localparam int MUL_A_W   = 32;
    localparam int COEF_W    = 28;
    localparam int PROD_W    = MUL_A_W + COEF_W;
    localparam int LO_W      = 16;
    localparam int LO_PROD_W = LO_W + COEF_W;
    localparam int FULL_W    = PROD_W + LO_W;
    localparam int QUOT_W    = 12;

    // Q.24 coefficients, rounded to nearest
    localparam logic [COEF_W-1:0] C_A1  = 28'd8221;
    localparam logic [COEF_W-1:0] C_A2  = 28'd8053;
    localparam logic [COEF_W-1:0] C_B1  = 28'd33017561;
    localparam logic [COEF_W-1:0] C_B2  = 28'd16258800;
    localparam logic [COEF_W-1:0] C_KP  = 28'd2516582;
    localparam logic [COEF_W-1:0] C_KI  = 28'd6710886;
    localparam logic [COEF_W-1:0] C_KD  = 28'd41943040;
    localparam logic [COEF_W-1:0] C_KPP = 28'd3690988;
    localparam logic [COEF_W-1:0] C_KIP = 28'd5872026;
    localparam logic [COEF_W-1:0] C_KDP = 28'd167772160;
    // err * 2^24 / 200 = err * 83886 + floor(2 * err / 25);
    // the last term is (2 * err * ceil(2^30 / 25)) >> 30.
    localparam logic [COEF_W-1:0] C_DIV200_INT = 28'd83886;
    localparam logic [COEF_W-1:0] C_RECIP25    = 28'd42949673;

    localparam logic [4:0] SH_NONE  = 5'd0;
    localparam logic [4:0] SH_Q     = 5'd24;
    localparam logic [4:0] SH_RECIP = 5'd30;

    typedef enum logic [1:0] {
        FUNC_EDGE  = 2'd0,
        FUNC_CTRL  = 2'd1,
        FUNC_SUPER = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_ACCEL = 3'd1,
        ST_DECEL = 3'd2,
        ST_SPEED = 3'd3,
        ST_POS   = 3'd4
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DM_NONE  = 3'd0,
        DM_STOP  = 3'd1,
        DM_ACCEL = 3'd2,
        DM_DECEL = 3'd3,
        DM_CW    = 3'd4,
        DM_CCW   = 3'd5
    } drive_mode_t;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } pos_side_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_SETUP,
        SQ_OP_LO,
        SQ_OP_HI,
        SQ_OP_COMB,
        SQ_OP_ACC,
        SQ_FSAT,
        SQ_FSPEED,
        SQ_ERR,
        SQ_ISAT,
        SQ_PFIN,
        SQ_PDIV,
        SQ_DRIVE,
        SQ_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        SRC_FIN1,
        SRC_FIN2,
        SRC_FO1,
        SRC_FO2,
        SRC_ERR,
        SRC_ERR2,
        SRC_INT,
        SRC_DIFF
    } src_t;

    typedef struct packed {
        src_t              src;
        logic [COEF_W-1:0] coef;
        logic [4:0]        shift;
        logic              neg;
    } mac_op_t;

    localparam logic [3:0] OP_A1     = 4'd0;
    localparam logic [3:0] OP_A2     = 4'd1;
    localparam logic [3:0] OP_B1     = 4'd2;
    localparam logic [3:0] OP_B2     = 4'd3;
    localparam logic [3:0] OP_IDIV   = 4'd4;
    localparam logic [3:0] OP_IREM   = 4'd5;
    localparam logic [3:0] OP_KP     = 4'd6;
    localparam logic [3:0] OP_KI     = 4'd7;
    localparam logic [3:0] OP_KD     = 4'd8;

    localparam logic [2:0] PADDR_TARGET_POS = 3'd0;

    // Multiply-accumulate program of the control tick.
    function automatic mac_op_t mac_op(input logic [3:0] idx, input logic pos);
        mac_op_t r;
        case (idx)
            OP_A1:   r = '{SRC_FIN1, C_A1, SH_NONE, 1'b0};
            OP_A2:   r = '{SRC_FIN2, C_A2, SH_NONE, 1'b0};
            OP_B1:   r = '{SRC_FO1, C_B1, SH_Q, 1'b0};
            OP_B2:   r = '{SRC_FO2, C_B2, SH_Q, 1'b1};
            OP_IDIV: r = '{SRC_ERR, C_DIV200_INT, SH_NONE, 1'b0};
            OP_IREM: r = '{SRC_ERR2, C_RECIP25, SH_RECIP, 1'b0};
            OP_KP:   r = '{SRC_ERR, pos ? C_KPP : C_KP, SH_NONE, 1'b0};
            OP_KI:   r = '{SRC_INT, pos ? C_KIP : C_KI, SH_Q, 1'b0};
            OP_KD:   r = '{SRC_DIFF, pos ? C_KDP : C_KD, SH_NONE, 1'b0};
            default: r = '{SRC_FIN1, '0, SH_NONE, 1'b0};
        endcase
        return r;
    endfunction

    // Division by 2^FRAC_BITS, truncating toward zero.
    function automatic logic signed [39:0] trunc_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] b;
        b = v + (v[ACC_W-1] ? 64'sd16777215 : 64'sd0);
        return 40'(b >>> FRAC_BITS);
    endfunction

endpackage

/* hw/rtl/mpsc_if.sv */
// Valid/ready channel interfaces for the controller's item and result beats.
// Depends on mpsc_pkg for field widths.
interface mpsc_cmd_if
    import mpsc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic                     edge_reverse;
    logic signed [TS_W-1:0]   target_speed;
    logic                     position_request;

    modport source (output valid, func, edge_reverse, target_speed, position_request,
                    input ready);
    modport sink (input valid, func, edge_reverse, target_speed, position_request,
                  output ready);
endinterface

interface mpsc_rsp_if
    import mpsc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [7:0]                 pwm_compare;
    logic signed [SPEED_W-1:0]  filtered_speed;
    logic [2:0]                 control_state;
    logic                       reverse_flag;
    logic signed [POS_BITS-1:0] position_count;

    modport source (output valid, pwm_compare, filtered_speed, control_state, reverse_flag,
                    position_count, input ready);
    modport sink (input valid, pwm_compare, filtered_speed, control_state, reverse_flag,
                  position_count, output ready);
endinterface

/* hw/rtl/mpsc_mul.sv */
// Shared unsigned multiplier with a registered product, used for every
// filter and PID product. Depends on mpsc_pkg for operand widths.
module mpsc_mul
    import mpsc_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [COEF_W-1:0]  b,
    output logic [PROD_W-1:0]  p
);

    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

/* hw/rtl/motor_pid_speed_position_controller.sv */
// Motor speed/position controller: encoder counting, IIR speed filter, PID loops.
// Depends on mpsc_pkg, mpsc_if (channel interfaces) and mpsc_mul.
//
//   channel   dir  handshake           payload
//   cmd       in   valid/ready         func, edge_reverse, target_speed, position_request
//   rsp       out  valid/ready         pwm_compare, filtered_speed, control_state,
//                                      reverse_flag, position_count
//   apb       in   psel/penable/pready target_position at byte address 0
//
// An encoder edge, a supervisory tick or an unused code passes through the accepting
// state and then SQ_DONE, which loads the result register. Each product takes four
// steps in the one shared multiplier (low half, high half, combine, accumulate): nine
// products in the speed and position states, four in idle.
// cmd is not ready until the result has been moved into the output register, which
// waits for rsp.ready; a full output register stalls only the final load.
// Reset is asynchronous and active low; compare starts at 220, the other controller
// state at zero. The datapath scratch registers and the result payload are not reset.
module motor_pid_speed_position_controller
    import mpsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mpsc_cmd_if.sink    cmd,
    mpsc_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic signed [ACC_W-1:0] SAT48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT48_MIN = -64'sh0000_8000_0000_0000;
    localparam logic signed [ACC_W-1:0] INT_POS_MAX = 64'sd1040187392;
    localparam logic signed [ACC_W-1:0] INT_POS_MIN = -64'sd1040187392;

    seq_state_t                 seq_reg, seq_next;
    logic [3:0]                 op_reg, op_next;
    ctrl_state_t                ctrl_state_reg, ctrl_state_next;
    drive_mode_t                drive_mode_reg, drive_mode_next;
    pos_side_t                  pos_side_reg, pos_side_next;
    logic [7:0]                 idle_ticks_reg, idle_ticks_next;
    logic signed [EDGE_BITS-1:0] edge_count_reg, edge_count_next;
    logic signed [POS_BITS-1:0] pos_count_reg, pos_count_next;
    logic                       pos_mode_reg, pos_mode_next;
    logic                       neg_flag_reg, neg_flag_next;
    logic signed [FIN_W-1:0]    fin0_reg, fin0_next, fin1_reg, fin1_next, fin2_reg, fin2_next;
    logic signed [FILT_W-1:0]   fo0_reg, fo0_next, fo1_reg, fo1_next, fo2_reg, fo2_next;
    logic signed [SPEED_W-1:0]  speed_now_reg, speed_now_next;
    logic signed [TS_W-1:0]     setpoint_reg, setpoint_next;
    logic signed [ERR_W-1:0]    err_now_reg, err_now_next, err_prev_reg, err_prev_next;
    logic signed [FILT_W-1:0]   integral_reg, integral_next;
    logic signed [DRIVE_W-1:0]  drive_value_reg, drive_value_next;
    logic [7:0]                 pwm_cmp_reg, pwm_cmp_next;
    logic [15:0]                target_pos_reg;

    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ACC_W-1:0]    term_reg, term_next;
    logic [LO_PROD_W-1:0]       lo_reg;
    logic signed [QUOT_W-1:0]   quot_reg, quot_next;

    logic                       rsp_valid_reg, rsp_valid_next;
    logic [7:0]                 rsp_pwm_reg;
    logic signed [SPEED_W-1:0]  rsp_speed_reg;
    logic [2:0]                 rsp_state_reg;
    logic                       rsp_rev_reg;
    logic signed [POS_BITS-1:0] rsp_pos_reg;
    logic                       rsp_load;

    mac_op_t                    op_sel;
    logic signed [OPND_W-1:0]   opnd;
    logic                       opnd_neg;
    logic [MAG_W-1:0]           opnd_mag;
    logic [MUL_A_W-1:0]         mul_a;
    logic [PROD_W-1:0]          mul_p;
    logic [FULL_W-1:0]          full_prod;
    logic [FULL_W-1:0]          full_shifted;
    logic [ACC_W-2:0]           term_mag;

    logic signed [15:0]         spd;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    fsat;
    logic signed [39:0]         qv;
    logic [10:0]                quot_mag;
    logic [22:0]                quot_prod;
    logic signed [DRIVE_W-1:0]  quot_t;
    logic signed [10:0]         cmp_ext;
    logic signed [10:0]         dv_ext;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr == PADDR_TARGET_POS) ? {16'b0, target_pos_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_pos_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr == PADDR_TARGET_POS)
        begin
            target_pos_reg <= pwdata[15:0];
        end
    end

    // ---------------------------------------------------------------------
    // Shared multiplier and operand selection
    // ---------------------------------------------------------------------
    always_comb
    begin
        op_sel = mac_op(op_reg, ctrl_state_reg == ST_POS);
        case (op_sel.src)
            SRC_FIN1: opnd = OPND_W'(fin1_reg);
            SRC_FIN2: opnd = OPND_W'(fin2_reg);
            SRC_FO1:  opnd = OPND_W'(fo1_reg);
            SRC_FO2:  opnd = OPND_W'(fo2_reg);
            SRC_ERR:  opnd = OPND_W'(err_now_reg);
            SRC_ERR2: opnd = OPND_W'(err_now_reg) <<< 1;
            SRC_INT:  opnd = OPND_W'(integral_reg);
            SRC_DIFF: opnd = OPND_W'(err_now_reg) - OPND_W'(err_prev_reg);
            default:  opnd = '0;
        endcase
        opnd_neg = opnd[OPND_W-1];
        opnd_mag = MAG_W'(opnd_neg ? -opnd : opnd);
        mul_a    = (seq_reg == SQ_OP_LO) ? MUL_A_W'(opnd_mag[LO_W-1:0])
                                         : opnd_mag[MAG_W-1:LO_W];
    end

    mpsc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (op_sel.coef),
        .p   (mul_p)
    );

    // Magnitude product, floored after the shift, then signed: this truncates
    // the signed product toward zero.
    assign full_prod    = {mul_p, {LO_W{1'b0}}} + FULL_W'(lo_reg);
    assign full_shifted = full_prod >> op_sel.shift;
    assign term_mag     = full_shifted[ACC_W-2:0];

    // ---------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= SQ_IDLE;
            op_reg          <= '0;
            ctrl_state_reg  <= ST_IDLE;
            drive_mode_reg  <= DM_NONE;
            pos_side_reg    <= SIDE_NONE;
            idle_ticks_reg  <= '0;
            edge_count_reg  <= '0;
            pos_count_reg   <= '0;
            pos_mode_reg    <= 1'b0;
            neg_flag_reg    <= 1'b0;
            fin0_reg        <= '0;
            fin1_reg        <= '0;
            fin2_reg        <= '0;
            fo0_reg         <= '0;
            fo1_reg         <= '0;
            fo2_reg         <= '0;
            speed_now_reg   <= '0;
            setpoint_reg    <= '0;
            err_now_reg     <= '0;
            err_prev_reg    <= '0;
            integral_reg    <= '0;
            drive_value_reg <= '0;
            pwm_cmp_reg     <= 8'd220;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            seq_reg         <= seq_next;
            op_reg          <= op_next;
            ctrl_state_reg  <= ctrl_state_next;
            drive_mode_reg  <= drive_mode_next;
            pos_side_reg    <= pos_side_next;
            idle_ticks_reg  <= idle_ticks_next;
            edge_count_reg  <= edge_count_next;
            pos_count_reg   <= pos_count_next;
            pos_mode_reg    <= pos_mode_next;
            neg_flag_reg    <= neg_flag_next;
            fin0_reg        <= fin0_next;
            fin1_reg        <= fin1_next;
            fin2_reg        <= fin2_next;
            fo0_reg         <= fo0_next;
            fo1_reg         <= fo1_next;
            fo2_reg         <= fo2_next;
            speed_now_reg   <= speed_now_next;
            setpoint_reg    <= setpoint_next;
            err_now_reg     <= err_now_next;
            err_prev_reg    <= err_prev_next;
            integral_reg    <= integral_next;
            drive_value_reg <= drive_value_next;
            pwm_cmp_reg     <= pwm_cmp_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        term_reg <= term_next;
        quot_reg <= quot_next;
        if (seq_reg == SQ_OP_HI)
        begin
            lo_reg <= mul_p[LO_PROD_W-1:0];
        end
        if (rsp_load)
        begin
            rsp_pwm_reg   <= pwm_cmp_reg;
            rsp_speed_reg <= speed_now_reg;
            rsp_state_reg <= ctrl_state_reg;
            rsp_rev_reg   <= neg_flag_reg;
            rsp_pos_reg   <= pos_count_reg;
        end
    end

    assign cmd.ready          = (seq_reg == SQ_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.pwm_compare    = rsp_pwm_reg;
    assign rsp.filtered_speed = rsp_speed_reg;
    assign rsp.control_state  = rsp_state_reg;
    assign rsp.reverse_flag   = rsp_rev_reg;
    assign rsp.position_count = rsp_pos_reg;

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        seq_next         = seq_reg;
        op_next          = op_reg;
        ctrl_state_next  = ctrl_state_reg;
        drive_mode_next  = drive_mode_reg;
        pos_side_next    = pos_side_reg;
        idle_ticks_next  = idle_ticks_reg;
        edge_count_next  = edge_count_reg;
        pos_count_next   = pos_count_reg;
        pos_mode_next    = pos_mode_reg;
        neg_flag_next    = neg_flag_reg;
        fin0_next        = fin0_reg;
        fin1_next        = fin1_reg;
        fin2_next        = fin2_reg;
        fo0_next         = fo0_reg;
        fo1_next         = fo1_reg;
        fo2_next         = fo2_reg;
        speed_now_next   = speed_now_reg;
        setpoint_next    = setpoint_reg;
        err_now_next     = err_now_reg;
        err_prev_next    = err_prev_reg;
        integral_next    = integral_reg;
        drive_value_next = drive_value_reg;
        pwm_cmp_next     = pwm_cmp_reg;
        acc_next         = acc_reg;
        term_next        = term_reg;
        quot_next        = quot_reg;
        rsp_load         = 1'b0;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;

        spd          = 16'(EDGE_BITS'(edge_count_reg)) * 16'sd45;
        acc_sum      = acc_reg + term_reg;
        fsat         = (acc_reg > SAT48_MAX) ? SAT48_MAX
                     : ((acc_reg < SAT48_MIN) ? SAT48_MIN : acc_reg);
        qv           = trunc_q(acc_reg);
        quot_mag     = 11'(quot_reg[QUOT_W-1] ? -quot_reg : quot_reg);
        quot_prod    = 23'(quot_mag) * 23'd3277;
        quot_t       = quot_reg[QUOT_W-1] ? -DRIVE_W'(quot_prod[22:15])
                                          : DRIVE_W'(quot_prod[22:15]);
        cmp_ext      = 11'({1'b0, pwm_cmp_reg});
        dv_ext       = 11'(drive_value_reg);

        case (seq_reg)
            SQ_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (func_t'(cmd.func))
                        FUNC_EDGE:
                        begin
                            if (cmd.edge_reverse)
                            begin
                                if (edge_count_reg != {1'b1, {(EDGE_BITS-1){1'b0}}})
                                    edge_count_next = edge_count_reg - 1'b1;
                                if (pos_mode_reg && pos_count_reg != {1'b1, {(POS_BITS-1){1'b0}}})
                                    pos_count_next = pos_count_reg - 1'b1;
                            end
                            else
                            begin
                                if (edge_count_reg != {1'b0, {(EDGE_BITS-1){1'b1}}})
                                    edge_count_next = edge_count_reg + 1'b1;
                                if (pos_mode_reg && pos_count_reg != {1'b0, {(POS_BITS-1){1'b1}}})
                                    pos_count_next = pos_count_reg + 1'b1;
                            end
                            seq_next = SQ_DONE;
                        end
                        FUNC_CTRL:
                        begin
                            seq_next = SQ_SETUP;
                        end
                        FUNC_SUPER:
                        begin
                            setpoint_next = cmd.target_speed;
                            if (!cmd.position_request)
                                pos_mode_next = 1'b0;
                            case (ctrl_state_reg)
                                ST_IDLE:
                                begin
                                    drive_mode_next = DM_STOP;
                                    err_now_next    = '0;
                                    err_prev_next   = '0;
                                    integral_next   = '0;
                                    if (cmd.position_request && idle_ticks_reg > 8'd150)
                                    begin
                                        idle_ticks_next = 8'd1;
                                        ctrl_state_next = ST_POS;
                                        pos_mode_next   = 1'b1;
                                        pos_count_next  = '0;
                                    end
                                    else
                                    begin
                                        ctrl_state_next = (cmd.target_speed == '0) ? ST_IDLE
                                                                                  : ST_ACCEL;
                                        if (idle_ticks_reg != 8'd255)
                                            idle_ticks_next = idle_ticks_reg + 8'd1;
                                    end
                                end
                                ST_ACCEL:
                                begin
                                    if (err_now_reg > 25'sd6)
                                        drive_mode_next = DM_ACCEL;
                                    else
                                        ctrl_state_next = ST_SPEED;
                                    idle_ticks_next = '0;
                                end
                                ST_DECEL:
                                begin
                                    if (speed_now_reg < 16'sd90 && cmd.target_speed == '0)
                                    begin
                                        drive_mode_next = DM_STOP;
                                        ctrl_state_next = ST_IDLE;
                                    end
                                    if (drive_value_reg < 9'sd1)
                                        drive_value_next = '0;
                                    else
                                        drive_mode_next = DM_DECEL;
                                    idle_ticks_next = '0;
                                end
                                ST_SPEED:
                                begin
                                    if (!(err_now_reg > -25'sd5 && err_now_reg < 25'sd5))
                                        ctrl_state_next = (err_now_reg < -25'sd5) ? ST_DECEL
                                                                                 : ST_ACCEL;
                                end
                                ST_POS:
                                begin
                                    if (!cmd.position_request)
                                    begin
                                        ctrl_state_next = ST_IDLE;
                                        pos_mode_next   = 1'b0;
                                    end
                                    if (pos_count_reg != '0)
                                    begin
                                        if (pos_side_reg == SIDE_LEFT)
                                            drive_mode_next = DM_CW;
                                        else if (pos_side_reg == SIDE_RIGHT)
                                            drive_mode_next = DM_CCW;
                                    end
                                    else
                                    begin
                                        drive_mode_next = DM_STOP;
                                        if (err_now_reg == err_prev_reg)
                                            integral_next = '0;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                            seq_next = SQ_DONE;
                        end
                        default:
                        begin
                            seq_next = SQ_DONE;
                        end
                    endcase
                end
            end

            SQ_SETUP:
            begin
                neg_flag_next = edge_count_reg[EDGE_BITS-1];
                if (pos_count_reg < 0)
                    pos_side_next = SIDE_LEFT;
                if (pos_count_reg > 0)
                    pos_side_next = SIDE_RIGHT;
                edge_count_next = '0;
                // Filter history is cleared while the state machine is idle.
                if (ctrl_state_reg == ST_IDLE)
                begin
                    fin1_next = '0;
                    fin2_next = '0;
                    fo1_next  = '0;
                    fo2_next  = '0;
                end
                else
                begin
                    fin1_next = fin0_reg;
                    fin2_next = fin1_reg;
                    fo1_next  = fo0_reg;
                    fo2_next  = fo1_reg;
                end
                fin0_next = pos_mode_reg ? FIN_W'(pos_count_reg) : FIN_W'(spd);
                acc_next  = '0;
                op_next   = OP_A1;
                seq_next  = SQ_OP_LO;
            end

            SQ_OP_LO:
            begin
                seq_next = SQ_OP_HI;
            end

            SQ_OP_HI:
            begin
                seq_next = SQ_OP_COMB;
            end

            SQ_OP_COMB:
            begin
                term_next = (opnd_neg ^ op_sel.neg) ? -ACC_W'(term_mag) : ACC_W'(term_mag);
                seq_next  = SQ_OP_ACC;
            end

            SQ_OP_ACC:
            begin
                acc_next = acc_sum;
                case (op_reg)
                    OP_B2:   seq_next = SQ_FSAT;
                    OP_IREM: seq_next = SQ_ISAT;
                    OP_KD:   seq_next = SQ_PFIN;
                    default:
                    begin
                        op_next  = op_reg + 4'd1;
                        seq_next = SQ_OP_LO;
                    end
                endcase
            end

            SQ_FSAT:
            begin
                fo0_next  = pos_mode_reg ? FILT_W'(pos_count_reg) <<< FRAC_BITS
                                         : FILT_W'(fsat);
                acc_next  = fsat;
                seq_next  = SQ_FSPEED;
            end

            SQ_FSPEED:
            begin
                if (qv > 40'sd32767)
                    speed_now_next = 16'sh7FFF;
                else if (qv < -40'sd32768)
                    speed_now_next = -16'sh8000;
                else
                    speed_now_next = SPEED_W'(qv);
                seq_next = (ctrl_state_reg == ST_IDLE) ? SQ_DRIVE : SQ_ERR;
            end

            SQ_ERR:
            begin
                if (ctrl_state_reg == ST_POS)
                    err_now_next = ERR_W'($signed({1'b0, target_pos_reg})) - ERR_W'(pos_count_reg);
                else
                    err_now_next = ERR_W'(setpoint_reg) - ERR_W'(speed_now_reg);
                acc_next = ACC_W'(integral_reg);
                op_next  = OP_IDIV;
                seq_next = SQ_OP_LO;
            end

            SQ_ISAT:
            begin
                if (ctrl_state_reg == ST_POS)
                    integral_next = FILT_W'((acc_reg > INT_POS_MAX) ? INT_POS_MAX
                                          : ((acc_reg < INT_POS_MIN) ? INT_POS_MIN : acc_reg));
                else
                    integral_next = FILT_W'(fsat);
                acc_next = '0;
                op_next  = OP_KP;
                seq_next = SQ_OP_LO;
            end

            SQ_PFIN:
            begin
                if (ctrl_state_reg == ST_POS)
                begin
                    if (qv > 40'sd13)
                        drive_value_next = 9'sd13;
                    else if (qv < -40'sd13)
                        drive_value_next = -9'sd13;
                    else
                        drive_value_next = DRIVE_W'(qv);
                    seq_next = SQ_DRIVE;
                end
                else
                begin
                    // Clamp before the divide by ten so that the quotient is narrow.
                    if (qv > 40'sd2010)
                        quot_next = 12'sd2010;
                    else if (qv < -40'sd360)
                        quot_next = -12'sd360;
                    else
                        quot_next = QUOT_W'(qv);
                    seq_next = SQ_PDIV;
                end
            end

            SQ_PDIV:
            begin
                if (quot_t > 9'sd200)
                    drive_value_next = 9'sd200;
                else if (quot_t < -9'sd35)
                    drive_value_next = -9'sd35;
                else
                    drive_value_next = quot_t;
                seq_next = SQ_DRIVE;
            end

            SQ_DRIVE:
            begin
                case (drive_mode_reg)
                    DM_ACCEL:
                    begin
                        pwm_cmp_next  = (cmp_ext - dv_ext > 11'sd0) ? 8'(11'sd220 - dv_ext) : 8'd1;
                        err_prev_next = err_now_reg;
                    end
                    DM_DECEL:
                    begin
                        pwm_cmp_next  = (cmp_ext - dv_ext < 11'sd255) ? 8'(11'sd220 - dv_ext)
                                                                      : 8'd255;
                        err_prev_next = err_now_reg;
                    end
                    DM_STOP:
                    begin
                        pwm_cmp_next  = 8'd220;
                        err_prev_next = err_now_reg;
                    end
                    DM_CCW:
                    begin
                        if (pwm_cmp_reg != 8'd0)
                            pwm_cmp_next = 8'(11'sd228 - dv_ext);
                        err_prev_next = err_now_reg;
                    end
                    DM_CW:
                    begin
                        if (pwm_cmp_reg != 8'd255)
                            pwm_cmp_next = 8'(11'sd212 - dv_ext);
                        err_prev_next = err_now_reg;
                    end
                    default:
                    begin
                    end
                endcase
                seq_next = SQ_DONE;
            end

            SQ_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    seq_next       = SQ_IDLE;
                end
            end

            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

endmodule

/* dv/motor_pid_speed_position_controller_tb.sv */
// Self-checking testbench for the motor speed/position controller: encoder edges,
// control and supervisory ticks, checked beat by beat against an in-bench model.
// Depends on mpsc_pkg, mpsc_if and the controller RTL.
`timescale 1ns / 1ps

module motor_pid_speed_position_controller_tb;
    import mpsc_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [1:0]        func;
        logic              rev;
        logic signed [13:0] ts;
        logic              req;
    } ctrl_item_t;

    typedef struct packed {
        logic [7:0]         pwm;
        logic signed [15:0] fspeed;
        logic [2:0]         cstate;
        logic               rflag;
        logic signed [23:0] pcount;
    } motor_obs_t;

    typedef struct {
        ctrl_item_t it;
        logic       typed;
        motor_obs_t obs;
    } vec_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    mpsc_cmd_if cmd ();
    mpsc_rsp_if rsp ();

    motor_pid_speed_position_controller uut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Model state of the controller.
    longint m_state, m_dmode, m_idle, m_edges, m_pos, m_side, m_posmode, m_neg;
    longint m_fin[3];
    longint m_fout[3];
    longint m_speed, m_setp, m_err, m_err_prev, m_integ, m_drive, m_cmp, m_target;

    motor_obs_t obs_queue[$];
    int  errors = 0;
    bit  calm = 0;
    int  quiet_cycles = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint qcoef(longint n, longint d);
        return (n * (longint'(1) << FRAC_BITS) + d / 2) / d;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat_w(longint v, int bits);
        longint lim;
        lim = longint'(1) << (bits - 1);
        return clampl(v, -lim, lim - 1);
    endfunction

    // Product with a non-negative Q coefficient, truncated toward zero.
    function automatic longint mul_coef(longint v, longint c);
        longint unsigned m, hi, lo, r;
        m = (v < 0) ? longint'(-v) : longint'(v);
        hi = (m >> 16) * c;
        lo = (m & 64'hFFFF) * c;
        r = (hi + (lo >> 16)) >> (FRAC_BITS - 16);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic void model_reset();
        m_state = ST_IDLE; m_dmode = DM_NONE; m_idle = 0; m_edges = 0; m_pos = 0;
        m_side = SIDE_NONE; m_posmode = 0; m_neg = 0;
        for (int i = 0; i < 3; i++)
        begin
            m_fin[i] = 0;
            m_fout[i] = 0;
        end
        m_speed = 0; m_setp = 0; m_err = 0; m_err_prev = 0; m_integ = 0;
        m_drive = 0; m_cmp = 220; m_target = 0;
    endfunction

    function automatic void control_tick_step();
        longint q, spd, sum, t;
        q = longint'(1) << FRAC_BITS;
        m_neg = (m_edges < 0) ? 1 : 0;
        if (m_pos < 0) m_side = SIDE_LEFT;
        if (m_pos > 0) m_side = SIDE_RIGHT;
        spd = m_edges * 45;
        m_edges = 0;
        m_fout[2] = m_fout[1];
        m_fout[1] = m_fout[0];
        m_fin[2] = m_fin[1];
        m_fin[1] = m_fin[0];
        if (m_state == ST_IDLE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_fin[i] = 0;
                m_fout[i] = 0;
            end
        end
        m_fin[0] = sat_w(m_posmode != 0 ? m_pos : spd, 24);
        sum = qcoef(49, 100000) * m_fin[1] + qcoef(48, 100000) * m_fin[2]
            + mul_coef(m_fout[1], qcoef(1968, 1000)) - mul_coef(m_fout[2], qcoef(9691, 10000));
        m_fout[0] = sat_w(sum, 48);
        m_speed = sat_w(m_fout[0] / q, 16);
        if (m_posmode != 0)
            m_fout[0] = sat_w(m_pos * q, 48);

        if (m_state != ST_IDLE && m_state != ST_POS)
        begin
            m_err = sat_w(m_setp - m_speed, 25);
            m_integ = sat_w(m_integ + (m_err * q) / 200, 48);
            sum = qcoef(15, 100) * m_err + mul_coef(m_integ, qcoef(4, 10))
                + qcoef(25, 10) * (m_err - m_err_prev);
            t = (sum / q) / 10;
            m_drive = clampl(t, -35, 200);
        end
        if (m_state == ST_POS)
        begin
            m_err = sat_w(m_target - m_pos, 25);
            m_integ = clampl(m_integ + (m_err * q) / 200, -62 * q, 62 * q);
            sum = qcoef(22, 100) * m_err + mul_coef(m_integ, qcoef(35, 100))
                + 10 * q * (m_err - m_err_prev);
            m_drive = clampl(sum / q, -13, 13);
        end

        case (m_dmode)
            DM_ACCEL: m_cmp = (m_cmp - m_drive > 0) ? 220 - m_drive : 1;
            DM_DECEL: m_cmp = (m_cmp - m_drive < 255) ? 220 - m_drive : 255;
            DM_STOP:  m_cmp = 220;
            DM_CCW:   if (m_cmp > 0) m_cmp = 228 - m_drive;
            DM_CW:    if (m_cmp < 255) m_cmp = 212 - m_drive;
            default:  return;
        endcase
        m_cmp = m_cmp & 255;
        m_err_prev = m_err;
    endfunction

    function automatic void super_tick_step(longint tspeed, logic req);
        m_setp = tspeed;
        if (!req) m_posmode = 0;
        case (m_state)
            ST_IDLE:
            begin
                m_dmode = DM_STOP;
                m_err = 0;
                m_err_prev = 0;
                m_integ = 0;
                if (req && m_idle > 150)
                begin
                    m_idle = 0;
                    m_state = ST_POS;
                    m_posmode = 1;
                    m_pos = 0;
                end
                else
                    m_state = (m_setp == 0) ? ST_IDLE : ST_ACCEL;
                if (m_idle < 255) m_idle++;
            end
            ST_ACCEL:
            begin
                if (m_err > 6) m_dmode = DM_ACCEL;
                else m_state = ST_SPEED;
                m_idle = 0;
            end
            ST_DECEL:
            begin
                if (m_speed < 90 && m_setp == 0)
                begin
                    m_dmode = DM_STOP;
                    m_state = ST_IDLE;
                end
                if (m_drive < 1) m_drive = 0;
                else m_dmode = DM_DECEL;
                m_idle = 0;
            end
            ST_SPEED:
            begin
                if (!(m_err > -5 && m_err < 5))
                    m_state = (m_err < -5) ? ST_DECEL : ST_ACCEL;
            end
            ST_POS:
            begin
                if (!req)
                begin
                    m_state = ST_IDLE;
                    m_posmode = 0;
                end
                if (m_pos != 0)
                begin
                    if (m_side == SIDE_LEFT) m_dmode = DM_CW;
                    else if (m_side == SIDE_RIGHT) m_dmode = DM_CCW;
                end
                else
                begin
                    m_dmode = DM_STOP;
                    if (m_err == m_err_prev) m_integ = 0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic motor_obs_t motor_predict(ctrl_item_t it);
        motor_obs_t o;
        longint d;
        case (it.func)
            FUNC_EDGE:
            begin
                d = it.rev ? -1 : 1;
                m_edges = sat_w(m_edges + d, EDGE_BITS);
                if (m_posmode != 0) m_pos = sat_w(m_pos + d, POS_BITS);
            end
            FUNC_CTRL:  control_tick_step();
            FUNC_SUPER: super_tick_step(longint'(it.ts), it.req);
            default: ;
        endcase
        o.pwm = m_cmp[7:0];
        o.fspeed = m_speed[15:0];
        o.cstate = m_state[2:0];
        o.rflag = m_neg[0];
        o.pcount = m_pos[23:0];
        return o;
    endfunction

    // Sends one item; the expected beat is typed in when given, else predicted.
    task automatic send_item(ctrl_item_t it, logic typed = 1'b0, motor_obs_t typed_obs = '0);
        motor_obs_t o;
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.func <= it.func;
        cmd.edge_reverse <= it.rev;
        cmd.target_speed <= it.ts;
        cmd.position_request <= it.req;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        o = motor_predict(it);
        obs_queue.push_back(typed ? typed_obs : o);
    endtask

    task automatic drain_results();
        cmd.valid <= 1'b0;
        while (obs_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(logic [15:0] value);
        drain_results();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_TARGET_POS; pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        m_target = value;
        @(posedge clk);
    endtask

    function automatic ctrl_item_t mk(logic [1:0] f, logic r, logic signed [13:0] t, logic q);
        ctrl_item_t it;
        it.func = f; it.rev = r; it.ts = t; it.req = q;
        return it;
    endfunction

    // Speed loop traffic: edges mostly in one direction, ticks, setpoint changes, unused codes.
    task automatic speed_burst(int n);
        logic dir;
        logic signed [13:0] sp;
        int r;
        dir = $urandom_range(0, 1);
        sp = $urandom_range(0, 9) == 0 ? 14'($urandom) : 14'($signed($urandom_range(0, 1200)) - 300);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_item(mk(FUNC_EDGE, ($urandom_range(0, 9) == 0) ? !dir : dir, 14'($urandom), 1'b0));
            else if (r < 85)
                send_item(mk(FUNC_CTRL, $urandom_range(0, 1), 14'($urandom), $urandom_range(0, 1)));
            else if (r < 97)
            begin
                if ($urandom_range(0, 7) == 0) sp = 14'($urandom);
                send_item(mk(FUNC_SUPER, 1'b0, sp, $urandom_range(0, 9) == 0));
            end
            else
                send_item(mk(FUNC_NONE, $urandom_range(0, 1), 14'($urandom), $urandom_range(0, 1)));
        end
    endtask

    // Lets the motor settle in idle long enough, then holds position for a while.
    task automatic position_episode(int n);
        logic dir;
        int r;
        for (int i = 0; i < 175; i++)
        begin
            send_item(mk(FUNC_SUPER, 1'b0, 14'sd0, 1'b0));
            send_item(mk(FUNC_CTRL, 1'b0, 14'($urandom), 1'b0));
        end
        send_item(mk(FUNC_SUPER, 1'b0, 14'($urandom), 1'b1));
        dir = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_item(mk(FUNC_EDGE, ($urandom_range(0, 3) == 0) ? !dir : dir, 14'($urandom), 1'b1));
            else if (r < 85)
                send_item(mk(FUNC_CTRL, 1'b0, 14'($urandom), 1'b1));
            else
                send_item(mk(FUNC_SUPER, 1'b0, 14'($urandom), $urandom_range(0, 29) != 0));
            if ($urandom_range(0, 19) == 0) dir = !dir;
        end
    endtask

    always @(posedge clk)
        rsp.ready <= calm || ($urandom_range(0, 99) >= 30);

    function automatic void check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        motor_obs_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (obs_queue.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: pwm %0d speed %0d state %0d",
                         $time, rsp.pwm_compare, rsp.filtered_speed, rsp.control_state);
                errors++;
            end
            else
            begin
                e = obs_queue.pop_front();
                check_field("pwm_compare", e.pwm, rsp.pwm_compare);
                check_field("filtered_speed", e.fspeed, rsp.filtered_speed);
                check_field("control_state", e.cstate, rsp.control_state);
                check_field("reverse_flag", e.rflag, rsp.reverse_flag);
                check_field("position_count", e.pcount, rsp.position_count);
            end
        end
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    vec_row_t vectors[$];

    initial
    begin
        vec_row_t row;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cmd.valid = 1'b0; cmd.func = FUNC_NONE; cmd.edge_reverse = 1'b0;
        cmd.target_speed = '0; cmd.position_request = 1'b0;
        rsp.ready = 1'b0;
        model_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_target(16'd0);

        // Directed rows; typed results are the reset state and the first idle ticks.
        vectors = '{
            '{'{FUNC_NONE, 1'b1, 14'sd0, 1'b1}, 1'b1, '{8'd220, 16'sd0, 3'd0, 1'b0, 24'sd0}},
            '{'{FUNC_EDGE, 1'b0, 14'sd0, 1'b0}, 1'b0, '0},
            '{'{FUNC_EDGE, 1'b1, 14'sd0, 1'b0}, 1'b0, '0},
            '{'{FUNC_EDGE, 1'b1, 14'sd0, 1'b0}, 1'b0, '0},
            '{'{FUNC_CTRL, 1'b0, 14'sd0, 1'b0}, 1'b1, '{8'd220, 16'sd0, 3'd0, 1'b1, 24'sd0}},
            '{'{FUNC_SUPER, 1'b0, 14'sd0, 1'b0}, 1'b1, '{8'd220, 16'sd0, 3'd0, 1'b1, 24'sd0}},
            '{'{FUNC_CTRL, 1'b0, 14'sd0, 1'b0}, 1'b1, '{8'd220, 16'sd0, 3'd0, 1'b0, 24'sd0}},
            '{'{FUNC_SUPER, 1'b0, 14'sd8191, 1'b1}, 1'b0, '0},
            '{'{FUNC_EDGE, 1'b0, 14'sd0, 1'b0}, 1'b0, '0},
            '{'{FUNC_CTRL, 1'b0, 14'sd0, 1'b0}, 1'b0, '0},
            '{'{FUNC_SUPER, 1'b0, 14'sd8191, 1'b0}, 1'b0, '0},
            '{'{FUNC_CTRL, 1'b0, 14'sd0, 1'b0}, 1'b0, '0},
            '{'{FUNC_SUPER, 1'b0, -14'sd8192, 1'b0}, 1'b0, '0},
            '{'{FUNC_CTRL, 1'b1, -14'sd1, 1'b1}, 1'b0, '0},
            '{'{FUNC_SUPER, 1'b0, -14'sd8192, 1'b0}, 1'b0, '0},
            '{'{FUNC_CTRL, 1'b0, 14'sd0, 1'b0}, 1'b0, '0},
            '{'{FUNC_SUPER, 1'b1, 14'sd0, 1'b0}, 1'b0, '0},
            '{'{FUNC_CTRL, 1'b0, 14'sd0, 1'b0}, 1'b0, '0},
            '{'{FUNC_NONE, 1'b0, -14'sd1, 1'b0}, 1'b0, '0}
        };
        foreach (vectors[i])
        begin
            row = vectors[i];
            send_item(row.it, row.typed, row.obs);
        end

        speed_burst(150);
        // Long same-direction run drives the edge counter into saturation.
        calm = 1;
        for (int i = 0; i < 530; i++)
            send_item(mk(FUNC_EDGE, 1'b1, 14'($urandom), 1'b0));
        send_item(mk(FUNC_CTRL, 1'b0, 14'sd0, 1'b0));
        speed_burst(100);
        calm = 0;

        write_target(16'd65535);
        position_episode(150);
        speed_burst(50);

        write_target(16'd5);
        position_episode(150);

        write_target(16'($urandom));
        speed_burst(80);

        drain_results();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
